FILE: hw/rtl/fwwt_pkg.sv
`default_nettype none
// ============================================================================
// fwwt_pkg - shared types and constants of the futex wait/wake table
// Field widths, status codes, controller states and the command/status
// bundles between the controller and the datapath.
// ============================================================================
package fwwt_pkg;

    // Field widths of the request and response words
    localparam int MODE_W   = 32;
    localparam int ADDR_W   = 48;
    localparam int VALUE_W  = 32;
    localparam int TID_W    = 6;
    localparam int STATUS_W = 3;

    // Op word decoding: bit 7 is the private flag, bit 8 the clock select
    localparam int                  PRIVATE_BIT = 7;
    localparam logic [MODE_W-1:0]   CMD_STRIP   = 32'h0000_0180;
    localparam logic [MODE_W-1:0]   CMD_WAIT    = 32'h0000_0000;
    localparam logic [MODE_W-1:0]   CMD_WAKE    = 32'h0000_0001;
    localparam logic [VALUE_W-1:0]  WAKE_ONE    = 32'h0000_0001;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 3'd0,
        ST_AGAIN         = 3'd1,
        ST_INVALID       = 3'd2,
        ST_NOT_SUPPORTED = 3'd3,
        ST_TABLE_FULL    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_READ,
        S_UPDATE,
        S_MISS,
        S_REPORT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic take;     // ready for a request word
        logic check;    // evaluate argument checks, arm the slot scan
        logic scan;     // step the slot scan
        logic read_w;   // read the waiter bitmap of the matched slot
        logic update;   // modify the matched slot
        logic miss;     // handle a request whose address has no slot
        logic report;   // move the result into the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic accepted; // request word taken this cycle
        logic early;    // argument checks settle the result
        logic hit;      // scan found the address
        logic miss;     // scan finished without a match
        logic out_free; // output register can take a result
    } t_dp_sts;

    typedef struct packed {
        t_status            status;
        logic               block_caller;
        logic               woken_count;
        logic [TID_W-1:0]   woken_task;
    } t_result;

endpackage
`default_nettype wire

FILE: hw/rtl/fwwt_if.sv
`default_nettype none
// ============================================================================
// fwwt_if - request and response channels of the futex wait/wake table
// Valid/ready channels; a word moves when valid and ready are both high.
// ============================================================================
interface fwwt_req_if;
    logic                                   valid;
    logic                                   ready;
    logic        [fwwt_pkg::MODE_W-1:0]     mode;
    logic        [fwwt_pkg::ADDR_W-1:0]     address;
    logic signed [fwwt_pkg::VALUE_W-1:0]    current_value;
    logic signed [fwwt_pkg::VALUE_W-1:0]    expected_or_count;
    logic        [fwwt_pkg::TID_W-1:0]      task_id;

    modport source (
        output valid, mode, address, current_value, expected_or_count, task_id,
        input  ready
    );
    modport sink (
        input  valid, mode, address, current_value, expected_or_count, task_id,
        output ready
    );
endinterface

interface fwwt_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [fwwt_pkg::STATUS_W-1:0]      status;
    logic                               block_caller;
    logic                               woken_count;
    logic [fwwt_pkg::TID_W-1:0]         woken_task;

    modport source (
        output valid, status, block_caller, woken_count, woken_task,
        input  ready
    );
    modport sink (
        input  valid, status, block_caller, woken_count, woken_task,
        output ready
    );
endinterface
`default_nettype wire

FILE: hw/rtl/fwwt_ram.sv
`default_nettype none
// ============================================================================
// fwwt_ram - generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ============================================================================
module fwwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: hw/rtl/fwwt_ctrl.sv
`default_nettype none
// ============================================================================
// fwwt_ctrl - controller of the futex wait/wake table
// Sequences one request: check, slot scan, bitmap read-modify-write or miss handling, report.
// ============================================================================
module fwwt_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire fwwt_pkg::t_dp_sts  i_sts,
    output fwwt_pkg::t_dp_cmd       o_cmd
);

    fwwt_pkg::t_state r_state;
    fwwt_pkg::t_state n_state;

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fwwt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fwwt_pkg::S_IDLE: begin
                if (i_sts.accepted) n_state = fwwt_pkg::S_CHECK;
            end
            fwwt_pkg::S_CHECK: begin
                n_state = i_sts.early ? fwwt_pkg::S_REPORT : fwwt_pkg::S_SCAN;
            end
            fwwt_pkg::S_SCAN: begin
                if (i_sts.hit) begin
                    n_state = fwwt_pkg::S_READ;
                end else if (i_sts.miss) begin
                    n_state = fwwt_pkg::S_MISS;
                end
            end
            fwwt_pkg::S_READ:   n_state = fwwt_pkg::S_UPDATE;
            fwwt_pkg::S_UPDATE: n_state = fwwt_pkg::S_REPORT;
            fwwt_pkg::S_MISS:   n_state = fwwt_pkg::S_REPORT;
            fwwt_pkg::S_REPORT: begin
                if (i_sts.out_free) n_state = fwwt_pkg::S_IDLE;
            end
            default: n_state = fwwt_pkg::S_IDLE;
        endcase
    end

    // Commands per state
    always_comb begin
        o_cmd = '0;
        case (r_state)
            fwwt_pkg::S_IDLE:   o_cmd.take   = 1'b1;
            fwwt_pkg::S_CHECK:  o_cmd.check  = 1'b1;
            fwwt_pkg::S_SCAN:   o_cmd.scan   = 1'b1;
            fwwt_pkg::S_READ:   o_cmd.read_w = 1'b1;
            fwwt_pkg::S_UPDATE: o_cmd.update = 1'b1;
            fwwt_pkg::S_MISS:   o_cmd.miss   = 1'b1;
            fwwt_pkg::S_REPORT: o_cmd.report = 1'b1;
            default:            o_cmd        = '0;
        endcase
    end

`ifndef SYNTHESIS
    // A stalled result keeps the controller in the report state
    a_report_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fwwt_pkg::S_REPORT && !i_sts.out_free)
            |=> (r_state == fwwt_pkg::S_REPORT))
        else $error("report state left while output register busy");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/fwwt_dp.sv
`default_nettype none
// ============================================================================
// fwwt_dp - datapath of the futex wait/wake table
// Request registers, slot valid bits, address and waiter RAMs, slot scan,
// lowest-waiter encoder, result and output registers.
// ============================================================================
module fwwt_dp #(
    parameter int MAX_WAIT_TASKS  = 64,
    parameter int MAX_FUTEX_SLOTS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire fwwt_pkg::t_dp_cmd  i_cmd,
    output fwwt_pkg::t_dp_sts       o_sts,
    fwwt_req_if.sink                i_req,
    fwwt_rsp_if.source              o_rsp
);

    localparam int SW = (MAX_FUTEX_SLOTS > 1) ? $clog2(MAX_FUTEX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_FUTEX_SLOTS + 1);
    localparam int WW = MAX_WAIT_TASKS;
    localparam int TW = fwwt_pkg::TID_W;
    localparam logic [TW:0]   TID_LIMIT  = (TW + 1)'(MAX_WAIT_TASKS);
    localparam logic [CW-1:0] SCAN_END   = CW'(MAX_FUTEX_SLOTS);
    localparam logic [SW-1:0] LAST_SLOT  = SW'(MAX_FUTEX_SLOTS - 1);

    // Request registers
    logic        [fwwt_pkg::MODE_W-1:0]  r_mode;
    logic        [fwwt_pkg::ADDR_W-1:0]  r_address;
    logic signed [fwwt_pkg::VALUE_W-1:0] r_cur;
    logic signed [fwwt_pkg::VALUE_W-1:0] r_exp;
    logic        [TW-1:0]                r_tid;

    // Table and scan state
    logic [MAX_FUTEX_SLOTS-1:0] r_valid;
    logic [CW-1:0]              r_idx;
    logic                       r_cmp_vld;
    logic [SW-1:0]              r_cmp_idx;
    logic [SW-1:0]              r_free;
    logic                       r_free_found;
    logic [SW-1:0]              r_slot;

    fwwt_pkg::t_result          r_res;
    fwwt_pkg::t_result          n_res;
    fwwt_pkg::t_result          r_out;
    logic                       r_out_valid;

    logic [fwwt_pkg::MODE_W-1:0] cmd_code;
    logic                        is_wait;
    logic                        is_wake;
    logic                        early;
    fwwt_pkg::t_status           early_status;

    logic                        accepted;
    logic                        issue;
    logic                        hit;
    logic                        miss;
    logic                        out_free;
    logic                        res_ld;

    logic [fwwt_pkg::ADDR_W-1:0] a_rdata;
    logic                        a_we;
    logic [WW-1:0]               w_rdata;
    logic                        w_we;
    logic [SW-1:0]               w_waddr;
    logic [WW-1:0]               w_wdata;
    logic [WW-1:0]               tid_bit;
    logic [TW-1:0]               low_idx;
    logic                        w_any;
    logic                        v_set;
    logic                        v_clr;

    // Request handshake
    assign i_req.ready = i_cmd.take;
    assign accepted    = i_cmd.take && i_req.valid;

    // Capture the request word
    always_ff @(posedge i_clk) begin
        if (accepted) begin
            r_mode    <= i_req.mode;
            r_address <= i_req.address;
            r_cur     <= i_req.current_value;
            r_exp     <= i_req.expected_or_count;
            r_tid     <= i_req.task_id;
        end
    end

    // Decode the op word and run the argument checks in priority order
    assign cmd_code = r_mode & ~fwwt_pkg::CMD_STRIP;
    assign is_wait  = (cmd_code == fwwt_pkg::CMD_WAIT);
    assign is_wake  = (cmd_code == fwwt_pkg::CMD_WAKE);

    always_comb begin
        early        = 1'b1;
        early_status = fwwt_pkg::ST_OK;
        if (r_address == '0) begin
            early_status = fwwt_pkg::ST_INVALID;
        end else if (r_mode[fwwt_pkg::PRIVATE_BIT]) begin
            early_status = fwwt_pkg::ST_NOT_SUPPORTED;
        end else if (is_wait) begin
            if ({1'b0, r_tid} >= TID_LIMIT) begin
                early_status = fwwt_pkg::ST_INVALID;
            end else if (r_cur != r_exp) begin
                early_status = fwwt_pkg::ST_AGAIN;
            end else begin
                early = 1'b0;
            end
        end else if (is_wake) begin
            if (r_exp != fwwt_pkg::WAKE_ONE) begin
                early_status = fwwt_pkg::ST_NOT_SUPPORTED;
            end else begin
                early = 1'b0;
            end
        end else begin
            early_status = fwwt_pkg::ST_NOT_SUPPORTED;
        end
    end

    // Slot scan: read the address at r_idx, compare the registered read data against the request address
    assign issue = i_cmd.scan && (r_idx < SCAN_END);
    assign hit   = r_cmp_vld && r_valid[r_cmp_idx] && (a_rdata == r_address);
    assign miss  = r_cmp_vld && (r_cmp_idx == LAST_SLOT) && !hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_cmp_vld    <= 1'b0;
            r_cmp_idx    <= '0;
            r_free       <= '0;
            r_free_found <= 1'b0;
            r_slot       <= '0;
        end else if (i_cmd.check) begin
            r_idx        <= '0;
            r_cmp_vld    <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_cmd.scan) begin
            r_cmp_vld <= issue;
            if (issue) begin
                r_idx     <= r_idx + CW'(1);
                r_cmp_idx <= r_idx[SW-1:0];
                // Remember the lowest free slot for allocation
                if (!r_valid[r_idx[SW-1:0]] && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free       <= r_idx[SW-1:0];
                end
            end
            if (hit) begin
                r_slot <= r_cmp_idx;
            end
        end
    end

    // Lowest set waiter
    always_comb begin
        low_idx = '0;
        w_any   = 1'b0;
        for (int i = WW - 1; i >= 0; i--) begin
            if (w_rdata[i]) begin
                low_idx = TW'(i);
                w_any   = 1'b1;
            end
        end
    end

    assign tid_bit = WW'(1) << r_tid;

    // Table updates and result selection
    always_comb begin
        res_ld  = 1'b0;
        n_res   = '{status: fwwt_pkg::ST_OK, block_caller: 1'b0,
                    woken_count: 1'b0, woken_task: '0};
        a_we    = 1'b0;
        w_we    = 1'b0;
        w_waddr = r_slot;
        w_wdata = w_rdata | tid_bit;
        v_set   = 1'b0;
        v_clr   = 1'b0;
        if (i_cmd.check) begin
            res_ld       = early;
            n_res.status = early_status;
        end else if (i_cmd.update) begin
            res_ld = 1'b1;
            if (is_wait) begin
                w_we               = 1'b1;
                n_res.block_caller = 1'b1;
            end else if (w_any) begin
                w_we              = 1'b1;
                w_wdata           = w_rdata & ~(WW'(1) << low_idx);
                n_res.woken_count = 1'b1;
                n_res.woken_task  = low_idx;
            end else begin
                // Empty bitmap: free the slot
                v_clr = 1'b1;
            end
        end else if (i_cmd.miss) begin
            res_ld = 1'b1;
            if (is_wait) begin
                if (r_free_found) begin
                    a_we               = 1'b1;
                    w_we               = 1'b1;
                    w_waddr            = r_free;
                    w_wdata            = tid_bit;
                    v_set              = 1'b1;
                    n_res.block_caller = 1'b1;
                end else begin
                    n_res.status = fwwt_pkg::ST_TABLE_FULL;
                end
            end
        end
    end

    // Slot valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (v_set) r_valid[r_free] <= 1'b1;
            if (v_clr) r_valid[r_slot] <= 1'b0;
        end
    end

    // Hold the result until the report step
    always_ff @(posedge i_clk) begin
        if (res_ld) begin
            r_res <= n_res;
        end
    end

    // Output register
    assign out_free = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.report && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.report && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.block_caller = r_out.block_caller;
    assign o_rsp.woken_count  = r_out.woken_count;
    assign o_rsp.woken_task   = r_out.woken_task;

    // Address and waiter stores
    fwwt_ram #(
        .WIDTH (fwwt_pkg::ADDR_W),
        .DEPTH (MAX_FUTEX_SLOTS)
    ) u_addr_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (r_free),
        .i_wdata (r_address),
        .i_raddr (r_idx[SW-1:0]),
        .o_rdata (a_rdata)
    );

    fwwt_ram #(
        .WIDTH (WW),
        .DEPTH (MAX_FUTEX_SLOTS)
    ) u_wait_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_slot),
        .o_rdata (w_rdata)
    );

    // Status to the controller
    assign o_sts.accepted = accepted;
    assign o_sts.early    = early;
    assign o_sts.hit      = hit;
    assign o_sts.miss     = miss;
    assign o_sts.out_free = out_free;

`ifndef SYNTHESIS
    // An allocation leaves its slot marked in use
    a_alloc_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_we |=> r_valid[$past(r_free)])
        else $error("allocated slot not marked valid");

    // A blocked caller always comes with an ok status
    a_block_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.block_caller) |-> (r_out.status == fwwt_pkg::ST_OK))
        else $error("block_caller set with non-ok status");

    // A result never both blocks the caller and wakes a task
    a_block_wake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.block_caller && r_out.woken_count))
        else $error("result both blocks and wakes");

    // A miss is only reported once every slot has been read
    a_miss_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan && miss) |-> (r_idx == SCAN_END))
        else $error("scan missed before covering all slots");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/futex_wait_wake_table.sv
`default_nettype none
// ============================================================================
// futex_wait_wake_table - futex wait/wake lookup table
// Holds futex addresses with a bitmap of waiting tasks per address.
// ============================================================================
// Usage:
//   i_req carries one request word: op word, futex address, current memory
//   value, expected value or wake count, and caller task id. o_rsp returns
//   exactly one response word per request: status, block flag, woken count
//   and woken task id. Both channels move a word when valid and ready are high.
//   Requests are handled one at a time. A request rejected by the argument
//   checks goes from the check step straight to the report step. A table
//   operation scans the address store one slot per cycle through its single
//   read port, stopping at the first match or after the last slot, then
//   reads and updates the waiter bitmap or handles the miss, and reports.
//   The output register decouples the sides: a new request is taken while a
//   response still waits; a stalled receiver holds the next response in the
//   result register, and the block stops taking requests until it moves.
//   Reset (synchronous, active low) empties the table by clearing every slot
//   valid bit at once; the block leaves reset idle and ready for a request.
// ============================================================================
module futex_wait_wake_table #(
    parameter int MAX_WAIT_TASKS  = 64,
    parameter int MAX_FUTEX_SLOTS = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    fwwt_req_if.sink    i_req,
    fwwt_rsp_if.source  o_rsp
);

    fwwt_pkg::t_dp_cmd cmd;
    fwwt_pkg::t_dp_sts sts;

    // Sequencer
    fwwt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Table, scan and result path
    fwwt_dp #(
        .MAX_WAIT_TASKS  (MAX_WAIT_TASKS),
        .MAX_FUTEX_SLOTS (MAX_FUTEX_SLOTS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule
`default_nettype wire

FILE: verif/tb_futex_wait_wake_table.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_futex_wait_wake_table - self-checking bench for the futex wait/wake table
// Request words are driven from a queue under random sender idling and
// receiver stalls. A predictor of the slot table works out the
// response of every accepted word, and each response word is checked field
// by field against the oldest prediction. A directed opener covers the
// argument checks and corner cases. Random traffic follows, mostly
// well-formed waits and wakes over a small address pool so that entries
// fill up, overflow and drain.
// ============================================================================
module tb_futex_wait_wake_table;

    localparam int          NUM_SLOTS    = 16;
    localparam int          NUM_TASKS    = 64;
    localparam int          POOL_SIZE    = 24;
    localparam int          PHASE_WORDS  = 630;
    localparam int          LONG_HOLD    = 300;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          PRINT_CAP    = 40;
    localparam logic [31:0] CLOCK_SEL    = 32'h0000_0100;
    localparam logic [31:0] PRIVATE_FLAG = 32'h1 << fwwt_pkg::PRIVATE_BIT;
    localparam logic [31:0] CMD_UNKNOWN  = 32'h0000_0002;
    localparam logic [31:0] INT_MIN      = 32'h8000_0000;
    localparam logic [31:0] INT_MAX      = 32'h7FFF_FFFF;
    localparam logic [47:0] ADDR_TOP     = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [fwwt_pkg::MODE_W-1:0]  mode;
        logic [fwwt_pkg::ADDR_W-1:0]  address;
        logic [fwwt_pkg::VALUE_W-1:0] current_value;
        logic [fwwt_pkg::VALUE_W-1:0] expected_or_count;
        logic [fwwt_pkg::TID_W-1:0]   task_id;
    } t_req_word;

    logic i_clk;
    logic i_rst_n;

    fwwt_req_if req_ch ();
    fwwt_rsp_if rsp_ch ();

    futex_wait_wake_table DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // Predicted slot table
    logic                          entry_live [NUM_SLOTS];
    logic [fwwt_pkg::ADDR_W-1:0]   entry_addr [NUM_SLOTS];
    logic [63:0]                   waiter_map [NUM_SLOTS];

    t_req_word                     pending_words[$];
    fwwt_pkg::t_result             expected_rsp[$];
    logic [fwwt_pkg::ADDR_W-1:0]   addr_pool [POOL_SIZE];

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  holds_asked    = 0;
    int  holds_done     = 0;
    int  hold_left      = 0;
    int  offer_mark     = -1;
    int  error_count    = 0;
    int  words_in       = 0;
    int  words_out      = 0;
    int  wakes_hit      = 0;
    int  cycle_count    = 0;
    int  status_tally [5];

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Known values on every input from time zero
    initial begin
        req_ch.valid             = 1'b0;
        req_ch.mode              = '0;
        req_ch.address           = '0;
        req_ch.current_value     = '0;
        req_ch.expected_or_count = '0;
        req_ch.task_id           = '0;
        rsp_ch.ready             = 1'b0;
        foreach (status_tally[k]) status_tally[k] = 0;
        foreach (entry_live[k]) begin
            entry_live[k] = 1'b0;
            entry_addr[k] = '0;
            waiter_map[k] = '0;
        end
    end

    // Work out the response of one request word and update the table
    function automatic fwwt_pkg::t_result futex_predict(input t_req_word w);
        fwwt_pkg::t_result              r;
        logic [fwwt_pkg::MODE_W-1:0]    cmd;
        logic [63:0]                    bits;
        int                             hit;
        int                             free_slot;
        int                             i;
        r.status       = fwwt_pkg::ST_OK;
        r.block_caller = 1'b0;
        r.woken_count  = 1'b0;
        r.woken_task   = '0;
        cmd            = w.mode & ~fwwt_pkg::CMD_STRIP;
        hit            = -1;
        free_slot      = -1;
        for (i = 0; i < NUM_SLOTS; i++) begin
            if (entry_live[i] && entry_addr[i] == w.address && hit < 0) hit = i;
            if (!entry_live[i] && free_slot < 0) free_slot = i;
        end
        if (w.address == '0) begin
            r.status = fwwt_pkg::ST_INVALID;
        end else if (w.mode[fwwt_pkg::PRIVATE_BIT]) begin
            r.status = fwwt_pkg::ST_NOT_SUPPORTED;
        end else if (cmd == fwwt_pkg::CMD_WAIT) begin
            if (int'(w.task_id) >= NUM_TASKS) begin
                r.status = fwwt_pkg::ST_INVALID;
            end else if (w.current_value != w.expected_or_count) begin
                r.status = fwwt_pkg::ST_AGAIN;
            end else begin
                // Allocate the lowest free entry on a miss
                if (hit < 0 && free_slot >= 0) begin
                    hit                   = free_slot;
                    entry_live[hit]       = 1'b1;
                    entry_addr[hit]       = w.address;
                    waiter_map[hit]       = '0;
                end
                if (hit < 0) begin
                    r.status = fwwt_pkg::ST_TABLE_FULL;
                end else begin
                    waiter_map[hit][w.task_id] = 1'b1;
                    r.block_caller             = 1'b1;
                end
            end
        end else if (cmd == fwwt_pkg::CMD_WAKE) begin
            if (w.expected_or_count != fwwt_pkg::WAKE_ONE) begin
                r.status = fwwt_pkg::ST_NOT_SUPPORTED;
            end else if (hit >= 0) begin
                bits = waiter_map[hit];
                if (bits == '0) begin
                    // An empty entry is released by the wake that finds it
                    entry_live[hit] = 1'b0;
                end else begin
                    for (i = NUM_TASKS - 1; i >= 0; i--)
                        if (bits[i]) r.woken_task = i[fwwt_pkg::TID_W-1:0];
                    waiter_map[hit][r.woken_task] = 1'b0;
                    r.woken_count                 = 1'b1;
                end
            end
        end else begin
            r.status = fwwt_pkg::ST_NOT_SUPPORTED;
        end
        return r;
    endfunction

    task automatic enqueue_word(input logic [31:0] mode, input logic [47:0] address,
                                input logic [31:0] cur, input logic [31:0] exp_cnt,
                                input logic [5:0] tid);
        t_req_word w;
        w.mode              = mode;
        w.address           = address;
        w.current_value     = cur;
        w.expected_or_count = exp_cnt;
        w.task_id           = tid;
        pending_words.push_back(w);
    endtask

    // Mostly well-formed waits and wakes on the pool, with some noise
    task automatic enqueue_random(input int wait_pct);
        logic [31:0] mode;
        logic [47:0] address;
        logic [31:0] cur;
        logic [31:0] exp_cnt;
        int          pick;
        pick    = $urandom_range(99);
        address = addr_pool[$urandom_range(POOL_SIZE - 1)];
        cur     = $urandom;
        exp_cnt = cur;
        mode    = $urandom_range(1) ? CLOCK_SEL : 32'h0;
        if (pick < wait_pct) begin
            mode = mode | fwwt_pkg::CMD_WAIT;
        end else if (pick < 92) begin
            mode    = mode | fwwt_pkg::CMD_WAKE;
            exp_cnt = fwwt_pkg::WAKE_ONE;
        end else begin
            mode = mode | ($urandom_range(1) ? fwwt_pkg::CMD_WAKE : fwwt_pkg::CMD_WAIT);
            case ($urandom_range(5))
                0: address = '0;
                1: mode = $urandom;
                2: exp_cnt = $urandom;
                3: begin
                    mode    = mode | fwwt_pkg::CMD_WAKE;
                    exp_cnt = $urandom_range(1) ? $urandom : $urandom_range(3);
                end
                4: address = 48'({$urandom, $urandom});
                default: mode = $urandom | PRIVATE_FLAG;
            endcase
        end
        enqueue_word(mode, address, cur, exp_cnt, 6'($urandom_range(NUM_TASKS - 1)));
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (error_count < PRINT_CAP)
            $display("ERROR @%0t: %s got %0d expected %0d (response %0d)",
                     $time, what, got, want, words_out);
        error_count++;
    endtask

    // Request driver: offer the head of the queue, hold it until taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (req_ch.valid && words_in == offer_mark) begin
            // hold the offered word
        end else if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_ch.valid             <= 1'b1;
            req_ch.mode              <= pending_words[0].mode;
            req_ch.address           <= pending_words[0].address;
            req_ch.current_value     <= pending_words[0].current_value;
            req_ch.expected_or_count <= pending_words[0].expected_or_count;
            req_ch.task_id           <= pending_words[0].task_id;
            offer_mark = words_in;
        end else begin
            req_ch.valid <= 1'b0;
        end
    end

    // Predict on every accepted request word
    always @(posedge i_clk) begin
        t_req_word w;
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            w.mode              = req_ch.mode;
            w.address           = req_ch.address;
            w.current_value     = req_ch.current_value;
            w.expected_or_count = req_ch.expected_or_count;
            w.task_id           = req_ch.task_id;
            expected_rsp.push_back(futex_predict(w));
            void'(pending_words.pop_front());
            words_in++;
        end
    end

    // Response receiver: random stalls plus the long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (holds_done < holds_asked) begin
            rsp_ch.ready <= 1'b0;
            hold_left  = LONG_HOLD - 1;
            holds_done = holds_done + 1;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Response monitor: compare against the oldest prediction
    always @(posedge i_clk) begin
        fwwt_pkg::t_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            words_out++;
            if (rsp_ch.status < 3'd5) status_tally[rsp_ch.status]++;
            if (rsp_ch.woken_count) wakes_hit++;
            if (expected_rsp.size() == 0) begin
                report_mismatch("unexpected response, status", rsp_ch.status, -1);
            end else begin
                want = expected_rsp.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", rsp_ch.status, want.status);
                if (rsp_ch.block_caller !== want.block_caller)
                    report_mismatch("block_caller", rsp_ch.block_caller, want.block_caller);
                if (rsp_ch.woken_count !== want.woken_count)
                    report_mismatch("woken_count", rsp_ch.woken_count, want.woken_count);
                if (rsp_ch.woken_task !== want.woken_task)
                    report_mismatch("woken_task", rsp_ch.woken_task, want.woken_task);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses still due",
                     cycle_count, expected_rsp.size());
            $display("FAIL futex_wait_wake_table");
            $finish;
        end
    end

    // Stimulus sequence
    initial begin
        int phase;
        int n;
        int wait_pct;
        i_rst_n = 1'b0;
        addr_pool[0] = ADDR_TOP;
        addr_pool[1] = 48'h1;
        for (n = 2; n < POOL_SIZE; n++) begin
            addr_pool[n] = 48'({$urandom, $urandom});
            if (addr_pool[n] == '0) addr_pool[n] = 48'h2;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct  = 33;
        recv_stall_pct = 82;

        // Directed opener: extremes, argument checks and table corner cases
        enqueue_word(fwwt_pkg::CMD_WAIT, ADDR_TOP, INT_MIN, INT_MIN, 6'd63);
        enqueue_word(fwwt_pkg::CMD_WAIT | CLOCK_SEL, ADDR_TOP, INT_MAX, INT_MAX, 6'd0);
        enqueue_word(fwwt_pkg::CMD_WAIT, ADDR_TOP, 32'd7, 32'd7, 6'd63);
        enqueue_word(fwwt_pkg::CMD_WAIT, ADDR_TOP, 32'd7, 32'd8, 6'd12);
        enqueue_word(fwwt_pkg::CMD_WAIT, 48'h0, 32'd3, 32'd3, 6'd1);
        enqueue_word(fwwt_pkg::CMD_WAKE, 48'h0, 32'd0, fwwt_pkg::WAKE_ONE, 6'd1);
        enqueue_word(fwwt_pkg::CMD_WAIT | PRIVATE_FLAG, ADDR_TOP, 32'd0, 32'd0, 6'd2);
        enqueue_word(fwwt_pkg::CMD_WAKE | PRIVATE_FLAG, ADDR_TOP, 32'd0,
                     fwwt_pkg::WAKE_ONE, 6'd2);
        enqueue_word(CMD_UNKNOWN, ADDR_TOP, 32'd0, 32'd0, 6'd2);
        enqueue_word(32'hFFFF_FFFF, ADDR_TOP, 32'd0, 32'd0, 6'd2);
        enqueue_word(~(PRIVATE_FLAG | CLOCK_SEL), ADDR_TOP, 32'd0, 32'd0, 6'd2);
        enqueue_word(fwwt_pkg::CMD_WAKE, ADDR_TOP, 32'd0, 32'd0, 6'd3);
        enqueue_word(fwwt_pkg::CMD_WAKE, ADDR_TOP, 32'd0, INT_MAX, 6'd3);
        enqueue_word(fwwt_pkg::CMD_WAKE, ADDR_TOP, 32'd0, 32'hFFFF_FFFF, 6'd3);
        enqueue_word(fwwt_pkg::CMD_WAKE, ADDR_TOP, 32'd0, INT_MIN, 6'd3);
        enqueue_word(fwwt_pkg::CMD_WAKE, 48'h1, 32'd0, fwwt_pkg::WAKE_ONE, 6'd4);
        enqueue_word(fwwt_pkg::CMD_WAKE | CLOCK_SEL, ADDR_TOP, 32'd0,
                     fwwt_pkg::WAKE_ONE, 6'd4);
        enqueue_word(fwwt_pkg::CMD_WAKE, ADDR_TOP, INT_MIN, fwwt_pkg::WAKE_ONE, 6'd4);
        enqueue_word(fwwt_pkg::CMD_WAKE, ADDR_TOP, 32'd0, fwwt_pkg::WAKE_ONE, 6'd4);
        enqueue_word(fwwt_pkg::CMD_WAIT, 48'h1, 32'd9, 32'd9, 6'd5);
        enqueue_word(fwwt_pkg::CMD_WAIT, 48'h8000_0000_0000, 32'd1, 32'd1, 6'd42);
        enqueue_word(fwwt_pkg::CMD_WAKE, 48'h1, 32'd0, fwwt_pkg::WAKE_ONE, 6'd6);
        enqueue_word(fwwt_pkg::CMD_WAKE, 48'h1, 32'd0, fwwt_pkg::WAKE_ONE, 6'd6);
        enqueue_word(fwwt_pkg::CMD_WAKE, 48'h1, 32'd0, fwwt_pkg::WAKE_ONE, 6'd6);

        // Random traffic in three idling phases; the wait share drifts so the
        // table alternately fills past capacity and drains
        for (phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct  = 82;
                recv_stall_pct = 33;
            end else if (phase == 2) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
                holds_asked    = holds_asked + 1;
            end
            for (n = 0; n < PHASE_WORDS; n++) begin
                if (n % 50 == 0) wait_pct = $urandom_range(15, 85);
                enqueue_random(wait_pct);
            end
            // pause until every outstanding response has arrived
            while (pending_words.size() != 0 || expected_rsp.size() != 0)
                @(posedge i_clk);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d request words, %0d responses, %0d tasks woken.",
                 words_in, words_out, wakes_hit);
        $display("Status mix ok/again/invalid/not_supported/table_full: %0d/%0d/%0d/%0d/%0d",
                 status_tally[0], status_tally[1], status_tally[2], status_tally[3],
                 status_tally[4]);
        if (error_count == 0) begin
            $display("PASS futex_wait_wake_table");
        end else begin
            $display("%0d mismatches", error_count);
            $display("FAIL futex_wait_wake_table");
        end
        $finish;
    end

endmodule
